// ===== src/bcdd_pkg.sv =====
package bcdd_pkg;

    // Fixed field widths
    localparam int TS_W       = 32;
    localparam int REQ_W      = 2;
    localparam int CODE_W     = 15;
    localparam int POS_W      = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int NUM_DIGITS = 4;
    localparam int DIG_IDX_W  = 2;

    // Decimal weights of the four digits, most significant first
    localparam int W_THOUSAND = 1000;
    localparam int W_HUNDRED  = 100;
    localparam int W_TEN      = 10;

    // Register reset values
    localparam logic [TS_W-1:0] GAP_RESET      = 32'd2000;
    localparam logic [TS_W-1:0] DEBOUNCE_RESET = 32'd50;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAP      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 1'd1;

    // Request codes on the input channel
    localparam logic [REQ_W-1:0] REQ_PULSE   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TIMEOUT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_UNUSED  = 2'd3;

    // Queue between the front and the back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef enum logic [1:0] {
        OP_PULSE,
        OP_TIMEOUT,
        OP_CLEAR,
        OP_NONE
    } t_op;

    typedef struct packed {
        t_op             op;
        logic [TS_W-1:0] ts;
    } t_item;

endpackage

// ===== src/bcdd_front.sv =====
module bcdd_front (
    input  logic                          i_valid,
    input  logic [bcdd_pkg::REQ_W-1:0]    i_req_type,
    input  logic [bcdd_pkg::TS_W-1:0]     i_timestamp,
    input  logic                          i_full,
    output logic                          o_stall,
    output logic                          o_push,
    output bcdd_pkg::t_item               o_item
);

    bcdd_pkg::t_op w_op;

    always_comb begin
        unique case (i_req_type)
            bcdd_pkg::REQ_PULSE:   w_op = bcdd_pkg::OP_PULSE;
            bcdd_pkg::REQ_TIMEOUT: w_op = bcdd_pkg::OP_TIMEOUT;
            bcdd_pkg::REQ_CLEAR:   w_op = bcdd_pkg::OP_CLEAR;
            bcdd_pkg::REQ_UNUSED:  w_op = bcdd_pkg::OP_NONE;
            default:               w_op = bcdd_pkg::OP_NONE;
        endcase
    end

    assign o_stall    = i_full;
    assign o_push     = i_valid && !i_full;
    assign o_item.op  = w_op;
    assign o_item.ts  = i_timestamp;

endmodule

// ===== src/bcdd_queue.sv =====
module bcdd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bcdd_pkg::t_item i_item,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_nonempty,
    output bcdd_pkg::t_item o_item
);

    bcdd_pkg::t_item                   r_mem [bcdd_pkg::QUEUE_DEPTH];
    logic [bcdd_pkg::QPTR_W-1:0]       r_wr_ptr;
    logic [bcdd_pkg::QPTR_W-1:0]       r_rd_ptr;
    logic [bcdd_pkg::QCNT_W-1:0]       r_count;
    logic [bcdd_pkg::QCNT_W-1:0]       n_count;
    logic                              w_pop;

    assign w_pop      = i_pop && (r_count != '0);
    assign o_full     = (r_count == bcdd_pkg::QCNT_W'(bcdd_pkg::QUEUE_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_item     = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== src/bcdd_back.sv =====
module bcdd_back #(
    parameter int MAX_PULSES = 15
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic [bcdd_pkg::TS_W-1:0]              i_gap,
    input  logic [bcdd_pkg::TS_W-1:0]              i_debounce,
    input  logic                                   i_nonempty,
    input  bcdd_pkg::t_item                        i_item,
    output logic                                   o_pop,
    input  logic                                   i_stall,
    output logic                                   o_valid,
    output logic                                   o_accepted,
    output logic                                   o_code_ready,
    output logic [bcdd_pkg::POS_W-1:0]             o_position,
    output logic [bcdd_pkg::NUM_DIGITS-1:0][$clog2(MAX_PULSES+1)-1:0] o_digits
);

    localparam int TALLY_W = $clog2(MAX_PULSES + 1);
    localparam logic [TALLY_W-1:0] TALLY_MAX = TALLY_W'(MAX_PULSES);
    localparam logic [bcdd_pkg::POS_W-1:0] POS_DONE = bcdd_pkg::POS_W'(bcdd_pkg::NUM_DIGITS);
    localparam logic [bcdd_pkg::POS_W-1:0] POS_LAST =
        bcdd_pkg::POS_W'(bcdd_pkg::NUM_DIGITS - 1);

    logic [TALLY_W-1:0]                          r_tally,  n_tally;
    logic [bcdd_pkg::TS_W-1:0]                   r_anchor, n_anchor;
    logic                                        r_anchor_valid, n_anchor_valid;
    logic [bcdd_pkg::POS_W-1:0]                  r_index,  n_index;
    logic [bcdd_pkg::NUM_DIGITS-1:0][TALLY_W-1:0] r_digits, n_digits;
    logic                                        r_ready,  n_ready;

    logic                                        r_out_valid;
    logic                                        r_out_acc;
    logic                                        r_out_ready;
    logic [bcdd_pkg::POS_W-1:0]                  r_out_pos;
    logic [bcdd_pkg::NUM_DIGITS-1:0][TALLY_W-1:0] r_out_digits, n_out_digits;

    logic                                        w_fire;
    logic                                        w_acc;
    logic                                        w_active;
    logic [bcdd_pkg::TS_W-1:0]                   w_elapsed;
    logic                                        w_pulse_ok;
    logic                                        w_timeout_ok;

    // The result register frees up in the same cycle its transfer completes.
    assign w_fire = i_nonempty && (!r_out_valid || !i_stall);
    assign o_pop  = w_fire;

    // Elapsed time wraps with the timestamp counter.
    assign w_elapsed    = i_item.ts - r_anchor;
    assign w_active     = !r_ready && (r_index < POS_DONE);
    assign w_pulse_ok   = w_active && (!r_anchor_valid || (w_elapsed > i_debounce));
    assign w_timeout_ok = w_active && r_anchor_valid && (w_elapsed > i_gap);

    always_comb begin
        n_tally        = r_tally;
        n_anchor       = r_anchor;
        n_anchor_valid = r_anchor_valid;
        n_index        = r_index;
        n_digits       = r_digits;
        n_ready        = r_ready;
        w_acc          = 1'b0;
        unique case (i_item.op)
            bcdd_pkg::OP_PULSE: begin
                if (w_pulse_ok) begin
                    w_acc          = 1'b1;
                    n_anchor       = i_item.ts;
                    n_anchor_valid = 1'b1;
                    if (r_tally != TALLY_MAX) begin
                        n_tally = r_tally + 1'b1;
                    end
                end
            end
            bcdd_pkg::OP_TIMEOUT: begin
                if (w_timeout_ok) begin
                    w_acc = 1'b1;
                    n_digits[r_index[bcdd_pkg::DIG_IDX_W-1:0]] = r_tally;
                    n_index  = r_index + 1'b1;
                    n_tally  = '0;
                    n_anchor = i_item.ts;
                    if (r_index == POS_LAST) begin
                        n_ready = 1'b1;
                    end
                end
            end
            bcdd_pkg::OP_CLEAR: begin
                n_tally        = '0;
                n_anchor       = '0;
                n_anchor_valid = 1'b0;
                n_index        = '0;
                n_digits       = '0;
                n_ready        = 1'b0;
            end
            bcdd_pkg::OP_NONE: begin
            end
            default: begin
            end
        endcase

        // A digit still being counted shows its live tally once it is nonzero.
        n_out_digits = n_digits;
        if ((n_index < POS_DONE) && (n_tally != '0)) begin
            n_out_digits[n_index[bcdd_pkg::DIG_IDX_W-1:0]] = n_tally;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tally        <= '0;
            r_anchor       <= '0;
            r_anchor_valid <= 1'b0;
            r_index        <= '0;
            r_digits       <= '0;
            r_ready        <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (w_fire) begin
                r_tally        <= n_tally;
                r_anchor       <= n_anchor;
                r_anchor_valid <= n_anchor_valid;
                r_index        <= n_index;
                r_digits       <= n_digits;
                r_ready        <= n_ready;
                r_out_valid    <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_acc    <= w_acc;
            r_out_ready  <= n_ready;
            r_out_pos    <= n_index;
            r_out_digits <= n_out_digits;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_accepted   = r_out_acc;
    assign o_code_ready = r_out_ready;
    assign o_position   = r_out_pos;
    assign o_digits     = r_out_digits;

endmodule

// ===== src/blink_code_digit_decoder.sv =====
// Four-digit blink code decoder.
// Input channel (i_valid / o_stall): one request per transfer, a pulse, a
// timeout check or a clear, each with its timestamp. Output channel
// (o_valid / i_stall): exactly one result per request, in request order,
// giving whether it was taken, whether the code is complete, the weighted
// code with the live count substituted, and the digit position.
// Configuration (i_cfg_valid / o_cfg_ready): index 0 sets the gap threshold,
// index 1 the debounce delay; writes are always taken and belong in idle time.
// Throughput is one request per cycle while the receiver does not stall. A
// request passes through the two-entry request queue and then through the
// state update into the result register.
// When the receiver stalls, the result holds, the next request waits in the
// queue, and o_stall rises once the queue is full; nothing is dropped.
// Reset clears the decoder state and the queue and returns the thresholds to
// 2000 and 50 time units; the block accepts requests as soon as reset is released.
module blink_code_digit_decoder #(
    parameter int MAX_PULSES = 15
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [bcdd_pkg::REQ_W-1:0]       i_req_type,
    input  logic [bcdd_pkg::TS_W-1:0]        i_timestamp,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic                             o_accepted,
    output logic                             o_code_ready,
    output logic [bcdd_pkg::CODE_W-1:0]      o_latest_code,
    output logic [bcdd_pkg::POS_W-1:0]       o_digit_position,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bcdd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bcdd_pkg::TS_W-1:0]        i_cfg_data
);

    localparam int TALLY_W = $clog2(MAX_PULSES + 1);
    // 1111 fits in 11 bits, so this holds the full weighted sum.
    localparam int SUM_W   = TALLY_W + 11;

    logic [bcdd_pkg::TS_W-1:0]                   r_gap;
    logic [bcdd_pkg::TS_W-1:0]                   r_debounce;

    logic                                        w_full;
    logic                                        w_push;
    bcdd_pkg::t_item                             w_front_item;
    logic                                        w_nonempty;
    bcdd_pkg::t_item                             w_queue_item;
    logic                                        w_pop;
    logic [bcdd_pkg::NUM_DIGITS-1:0][TALLY_W-1:0] w_digits;
    logic [SUM_W-1:0]                            w_code_sum;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap      <= bcdd_pkg::GAP_RESET;
            r_debounce <= bcdd_pkg::DEBOUNCE_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bcdd_pkg::CFG_GAP:      r_gap      <= i_cfg_data;
                bcdd_pkg::CFG_DEBOUNCE: r_debounce <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    bcdd_front u_front (
        .i_valid     (i_valid),
        .i_req_type  (i_req_type),
        .i_timestamp (i_timestamp),
        .i_full      (w_full),
        .o_stall     (o_stall),
        .o_push      (w_push),
        .o_item      (w_front_item)
    );

    bcdd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_item     (w_front_item),
        .i_pop      (w_pop),
        .o_full     (w_full),
        .o_nonempty (w_nonempty),
        .o_item     (w_queue_item)
    );

    bcdd_back #(
        .MAX_PULSES (MAX_PULSES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_gap        (r_gap),
        .i_debounce   (r_debounce),
        .i_nonempty   (w_nonempty),
        .i_item       (w_queue_item),
        .o_pop        (w_pop),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_accepted   (o_accepted),
        .o_code_ready (o_code_ready),
        .o_position   (o_digit_position),
        .o_digits     (w_digits)
    );

    // Constant weights reduce to shift-and-add networks.
    assign w_code_sum = SUM_W'(w_digits[0]) * SUM_W'(bcdd_pkg::W_THOUSAND)
                      + SUM_W'(w_digits[1]) * SUM_W'(bcdd_pkg::W_HUNDRED)
                      + SUM_W'(w_digits[2]) * SUM_W'(bcdd_pkg::W_TEN)
                      + SUM_W'(w_digits[3]);

    assign o_latest_code = w_code_sum[bcdd_pkg::CODE_W-1:0];

endmodule

// ===== dv/tb.sv =====
module tb;

    localparam int TALLY_MAX = 15;

    typedef struct {
        logic [bcdd_pkg::REQ_W-1:0] req;
        logic [bcdd_pkg::TS_W-1:0]  ts;
    } t_blink_event;

    typedef struct {
        logic                        accepted;
        logic                        ready;
        logic [bcdd_pkg::CODE_W-1:0] code;
        logic [bcdd_pkg::POS_W-1:0]  pos;
    } t_code_status;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_stall;
    logic [bcdd_pkg::REQ_W-1:0]     i_req_type;
    logic [bcdd_pkg::TS_W-1:0]      i_timestamp;
    logic                           o_valid;
    logic                           i_stall;
    logic                           o_accepted;
    logic                           o_code_ready;
    logic [bcdd_pkg::CODE_W-1:0]    o_latest_code;
    logic [bcdd_pkg::POS_W-1:0]     o_digit_position;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [bcdd_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [bcdd_pkg::TS_W-1:0]      i_cfg_data;

    t_blink_event blink_events[$];
    t_code_status predicted_status[$];

    // Decoder image kept alongside the block
    logic [bcdd_pkg::TS_W-1:0] gap_cfg;
    logic [bcdd_pkg::TS_W-1:0] debounce_cfg;
    int unsigned               tally;
    logic [bcdd_pkg::TS_W-1:0] anchor;
    logic                      anchor_seen;
    int unsigned               digit_at;
    int unsigned               digits[bcdd_pkg::NUM_DIGITS];
    logic                      code_done;

    logic                      event_taken;
    logic                      steady;
    logic                      sink_hold;
    int unsigned               mismatches;
    int unsigned               events_taken;
    int unsigned               events_queued;
    logic [bcdd_pkg::TS_W-1:0] stim_ts;

    blink_code_digit_decoder #(
        .MAX_PULSES(TALLY_MAX)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_req_type       (i_req_type),
        .i_timestamp      (i_timestamp),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_accepted       (o_accepted),
        .o_code_ready     (o_code_ready),
        .o_latest_code    (o_latest_code),
        .o_digit_position (o_digit_position),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic void clear_decoder();
        tally       = 0;
        anchor      = '0;
        anchor_seen = 1'b0;
        digit_at    = 0;
        code_done   = 1'b0;
        foreach (digits[i]) digits[i] = 0;
    endfunction

    function automatic t_code_status predict_decode(logic [bcdd_pkg::REQ_W-1:0] req,
                                                    logic [bcdd_pkg::TS_W-1:0] now);
        t_code_status              r;
        int unsigned               d[bcdd_pkg::NUM_DIGITS];
        int unsigned               sum;
        logic [bcdd_pkg::TS_W-1:0] since;
        r.accepted = 1'b0;
        since = now - anchor;
        case (req)
            bcdd_pkg::REQ_PULSE: begin
                if (!code_done && digit_at < bcdd_pkg::NUM_DIGITS &&
                    !(anchor_seen && since <= debounce_cfg)) begin
                    if (tally < TALLY_MAX) tally++;
                    anchor      = now;
                    anchor_seen = 1'b1;
                    r.accepted  = 1'b1;
                end
            end
            bcdd_pkg::REQ_TIMEOUT: begin
                if (!code_done && digit_at < bcdd_pkg::NUM_DIGITS && anchor_seen &&
                    since > gap_cfg) begin
                    digits[digit_at] = tally;
                    digit_at++;
                    tally  = 0;
                    anchor = now;
                    if (digit_at >= bcdd_pkg::NUM_DIGITS) code_done = 1'b1;
                    r.accepted = 1'b1;
                end
            end
            bcdd_pkg::REQ_CLEAR: clear_decoder();
            default: ;
        endcase
        d = digits;
        if (digit_at < bcdd_pkg::NUM_DIGITS && tally > 0) d[digit_at] = tally;
        sum     = d[0] * bcdd_pkg::W_THOUSAND + d[1] * bcdd_pkg::W_HUNDRED
                + d[2] * bcdd_pkg::W_TEN + d[3];
        r.ready = code_done;
        r.code  = sum[bcdd_pkg::CODE_W-1:0];
        r.pos   = digit_at[bcdd_pkg::POS_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic queue_event(input logic [bcdd_pkg::REQ_W-1:0] req,
                               input logic [bcdd_pkg::TS_W-1:0] ts);
        t_blink_event ev;
        ev.req = req;
        ev.ts  = ts;
        blink_events.push_back(ev);
        if (req != bcdd_pkg::REQ_UNUSED) events_queued++;
    endtask

    // Idle means nothing queued, nothing offered and no result outstanding.
    task automatic wait_idle();
        @(posedge i_clk);
        while (blink_events.size() != 0 || i_valid || predicted_status.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [bcdd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bcdd_pkg::TS_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == bcdd_pkg::CFG_GAP) gap_cfg = val;
        else debounce_cfg = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed codes: spaced pulses with some bounce, an occasional
    // premature timeout, then a timeout past the gap to close each digit.
    task automatic random_phase(input int unsigned target);
        int unsigned goal;
        int unsigned pick;
        int unsigned ndig;
        int unsigned npulse;
        goal = events_queued + target;
        while (events_queued < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 72) begin
                if ($urandom_range(0, 3) == 0) stim_ts = $urandom();
                ndig = $urandom_range(1, 6);
                for (int k = 0; k < ndig; k++) begin
                    npulse = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 18)
                                                         : $urandom_range(0, 9);
                    repeat (npulse) begin
                        if ($urandom_range(0, 4) == 0)
                            queue_event(bcdd_pkg::REQ_PULSE,
                                        stim_ts + $urandom_range(0, debounce_cfg));
                        stim_ts = stim_ts + debounce_cfg + 32'd1 + $urandom_range(0, 400);
                        queue_event(bcdd_pkg::REQ_PULSE, stim_ts);
                    end
                    if ($urandom_range(0, 5) == 0)
                        queue_event(bcdd_pkg::REQ_TIMEOUT,
                                    stim_ts + $urandom_range(0, gap_cfg));
                    stim_ts = stim_ts + gap_cfg + 32'd1 + $urandom_range(0, 400);
                    queue_event(bcdd_pkg::REQ_TIMEOUT, stim_ts);
                end
                if ($urandom_range(0, 9) < 6) queue_event(bcdd_pkg::REQ_CLEAR, $urandom());
            end else if (pick < 82) begin
                queue_event(bcdd_pkg::REQ_CLEAR, $urandom());
            end else if (pick < 90) begin
                queue_event(bcdd_pkg::REQ_UNUSED, $urandom());
            end else begin
                queue_event($urandom_range(0, 1) ? bcdd_pkg::REQ_TIMEOUT
                                                 : bcdd_pkg::REQ_PULSE, $urandom());
            end
        end
    endtask

    // Sender: a new transfer is offered only once the previous one has gone.
    always @(negedge i_clk) begin : driver
        t_blink_event ev;
        if (i_rst_n && (!i_valid || event_taken)) begin
            if (blink_events.size() != 0 && (steady || $urandom_range(0, 99) >= 29)) begin
                ev = blink_events.pop_front();
                i_valid     <= 1'b1;
                i_req_type  <= ev.req;
                i_timestamp <= ev.ts;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : receiver
        if (i_rst_n) i_stall <= sink_hold || (!steady && $urandom_range(0, 99) < 29);
    end

    always @(posedge i_clk) begin : monitor
        t_code_status want;
        if (!i_rst_n) begin
            event_taken <= 1'b0;
        end else begin
            event_taken <= i_valid && !o_stall;
            if (i_valid && !o_stall) begin
                predicted_status.push_back(predict_decode(i_req_type, i_timestamp));
                events_taken++;
            end
            if (o_valid && !i_stall) begin
                if (predicted_status.size() == 0) begin
                    report_mismatch("result transfer with no request outstanding");
                end else begin
                    want = predicted_status.pop_front();
                    if (o_accepted !== want.accepted)
                        report_mismatch($sformatf("accepted %0b, expected %0b",
                                                  o_accepted, want.accepted));
                    if (o_code_ready !== want.ready)
                        report_mismatch($sformatf("code_ready %0b, expected %0b",
                                                  o_code_ready, want.ready));
                    if (o_latest_code !== want.code)
                        report_mismatch($sformatf("latest_code %0d, expected %0d",
                                                  o_latest_code, want.code));
                    if (o_digit_position !== want.pos)
                        report_mismatch($sformatf("digit_position %0d, expected %0d",
                                                  o_digit_position, want.pos));
                end
            end
        end
    end

    // Long receiver hold-off so that the block backs up and stalls its input.
    initial begin : hold_off
        while (events_taken < 120) @(posedge i_clk);
        sink_hold = 1'b1;
        repeat (60) @(posedge i_clk);
        sink_hold = 1'b0;
    end

    initial begin : watchdog
        #2000000;
        $display("blink_code_digit_decoder regression: fail");
        $finish;
    end

    initial begin : stimulus
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_req_type    = bcdd_pkg::REQ_PULSE;
        i_timestamp   = '0;
        i_stall       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = bcdd_pkg::CFG_GAP;
        i_cfg_data    = '0;
        steady        = 1'b0;
        sink_hold     = 1'b0;
        mismatches    = 0;
        events_taken  = 0;
        events_queued = 0;
        stim_ts       = $urandom();
        gap_cfg       = bcdd_pkg::GAP_RESET;
        debounce_cfg  = bcdd_pkg::DEBOUNCE_RESET;
        clear_decoder();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        queue_event(bcdd_pkg::REQ_TIMEOUT, 32'd100);        // nothing seen yet
        queue_event(bcdd_pkg::REQ_PULSE, 32'd0);            // time zero is an ordinary pulse
        queue_event(bcdd_pkg::REQ_PULSE, 32'd50);           // bounce, exactly on the delay
        queue_event(bcdd_pkg::REQ_PULSE, 32'd51);
        queue_event(bcdd_pkg::REQ_TIMEOUT, 32'd2051);       // exactly on the gap, stays open
        queue_event(bcdd_pkg::REQ_TIMEOUT, 32'd2052);
        queue_event(bcdd_pkg::REQ_TIMEOUT, 32'd4053);       // closes an empty digit
        queue_event(bcdd_pkg::REQ_UNUSED, 32'hFFFF_FFFF);
        for (int i = 0; i < 16; i++)
            queue_event(bcdd_pkg::REQ_PULSE, 32'd4200 + 32'd100 * i);
        queue_event(bcdd_pkg::REQ_TIMEOUT, 32'hFFFF_FFF0);
        queue_event(bcdd_pkg::REQ_PULSE, 32'h0000_0030);    // spacing measured across the wrap
        queue_event(bcdd_pkg::REQ_TIMEOUT, 32'h0000_0900);  // fourth digit, code complete
        queue_event(bcdd_pkg::REQ_PULSE, 32'h0001_0000);
        queue_event(bcdd_pkg::REQ_TIMEOUT, 32'h0100_0000);
        queue_event(bcdd_pkg::REQ_CLEAR, 32'h0);

        random_phase(300);
        wait_idle();
        write_reg(bcdd_pkg::CFG_GAP, 32'd0);
        write_reg(bcdd_pkg::CFG_DEBOUNCE, 32'd0);
        random_phase(200);
        wait_idle();
        write_reg(bcdd_pkg::CFG_GAP, 32'hFFFF_FFFF);
        write_reg(bcdd_pkg::CFG_DEBOUNCE, 32'hFFFF_FFFF);
        random_phase(60);
        wait_idle();
        write_reg(bcdd_pkg::CFG_GAP, $urandom_range(1, 5000));
        write_reg(bcdd_pkg::CFG_DEBOUNCE, $urandom_range(0, 200));
        steady = 1'b1;
        random_phase(200);
        wait_idle();
        steady = 1'b0;
        write_reg(bcdd_pkg::CFG_GAP, 32'd100);
        write_reg(bcdd_pkg::CFG_DEBOUNCE, 32'd5);
        random_phase(200);
        wait_idle();
        write_reg(bcdd_pkg::CFG_GAP, $urandom());
        write_reg(bcdd_pkg::CFG_DEBOUNCE, $urandom());
        random_phase(60);
        wait_idle();
        write_reg(bcdd_pkg::CFG_GAP, bcdd_pkg::GAP_RESET);
        write_reg(bcdd_pkg::CFG_DEBOUNCE, bcdd_pkg::DEBOUNCE_RESET);
        random_phase(150);

        wait_idle();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("blink_code_digit_decoder regression: pass");
        end else begin
            $display("blink_code_digit_decoder regression: fail");
        end
        $finish;
    end
endmodule
